[hw/rtl/bbf_pkg.sv]
// Shared constants, types and codes of the RGB box blur filter.
`default_nettype none
package bbf_pkg;

    localparam int MAX_WINDOW = 7;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int DIM_W  = 11;
    localparam int WIN_W  = 3;
    localparam int BANK_W = $clog2(MAX_WINDOW);
    localparam int IDX_W  = COL_W + ROW_W;
    localparam int RCV_W  = 2 * DIM_W;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int LSUM_W = $clog2(MAX_WINDOW * 255 + 1);
    localparam int SUM_W  = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
    localparam int WIN_CAP = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;

    localparam int MOD_SHIFT = IDX_W + 4;
    localparam int MOD_RECIP = (2 ** MOD_SHIFT) / MAX_WINDOW + 1;
    localparam int PROD_W    = IDX_W + MOD_SHIFT;

    localparam logic [1:0] CFG_WINDOW = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pix_t;

    typedef struct packed {
        logic [LSUM_W-1:0] r;
        logic [LSUM_W-1:0] g;
        logic [LSUM_W-1:0] b;
    } lane_sum_t;

    typedef struct packed {
        logic wr_en;
        logic acc_clr;
        logic acc_en;
    } lane_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/bbf_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module bbf_div
    import bbf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [IDX_W-1:0] dividend,
    input  wire logic [DIM_W-1:0] divisor,
    output logic      [IDX_W-1:0] quot,
    output logic      [DIM_W-1:0] rem,
    output logic                  done
);
    localparam int DCNT_W = $clog2(IDX_W + 1);

    logic [IDX_W-1:0]  quo_reg;
    logic [DIM_W-1:0]  rem_reg;
    logic [DIM_W-1:0]  dvs_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              done_reg;
    logic [DIM_W:0]    shifted;
    logic [DIM_W:0]    trial;

    assign shifted = {rem_reg, quo_reg[IDX_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DCNT_W'(IDX_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == DCNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_reg <= trial[DIM_W-1:0];
                quo_reg <= {quo_reg[IDX_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DIM_W-1:0];
                quo_reg <= {quo_reg[IDX_W-2:0], 1'b0};
            end
        end
    end

    assign quot = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

[hw/rtl/bbf_lane.sv]
// One row bank of the line store with its column accumulator.
`default_nettype none
module bbf_lane
    import bbf_pkg::*;
(
    input  wire logic             clk,
    input  wire lane_ctl_t        ctl,
    input  wire logic [COL_W-1:0] wr_addr,
    input  wire pix_t             wr_pix,
    input  wire logic [COL_W-1:0] rd_addr,
    output pix_t                  rd_pix,
    output lane_sum_t             acc
);
    pix_t      mem [MAX_WIDTH];
    pix_t      rd_reg;
    lane_sum_t acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_pix;
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (ctl.acc_en)
        begin
            acc_reg.r <= acc_reg.r + LSUM_W'(rd_reg.r);
            acc_reg.g <= acc_reg.g + LSUM_W'(rd_reg.g);
            acc_reg.b <= acc_reg.b + LSUM_W'(rd_reg.b);
        end
    end

    assign rd_pix = rd_reg;
    assign acc    = acc_reg;
endmodule
`default_nettype wire

[hw/rtl/bbf_merge.sv]
// Merges lane sums into window totals and picks the pass-through pixel.
`default_nettype none
module bbf_merge
    import bbf_pkg::*;
(
    input  wire logic              clk,
    input  wire lane_sum_t         lane_acc [MAX_WINDOW],
    input  wire pix_t              lane_pix [MAX_WINDOW],
    input  wire logic [BANK_W-1:0] sel,
    input  wire logic              cap_sum,
    input  wire logic              cap_pix,
    output logic      [SUM_W-1:0]  sum_r,
    output logic      [SUM_W-1:0]  sum_g,
    output logic      [SUM_W-1:0]  sum_b,
    output pix_t                   pass_pix
);
    logic [SUM_W-1:0] tr, tg, tb;
    logic [SUM_W-1:0] sr_reg, sg_reg, sb_reg;
    pix_t             pix_reg;

    always_comb
    begin
        tr = '0;
        tg = '0;
        tb = '0;
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            tr = tr + SUM_W'(lane_acc[k].r);
            tg = tg + SUM_W'(lane_acc[k].g);
            tb = tb + SUM_W'(lane_acc[k].b);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_sum)
        begin
            sr_reg <= tr;
            sg_reg <= tg;
            sb_reg <= tb;
        end
        if (cap_pix)
        begin
            pix_reg <= lane_pix[sel];
        end
    end

    assign sum_r    = sr_reg;
    assign sum_g    = sg_reg;
    assign sum_b    = sb_reg;
    assign pass_pix = pix_reg;
endmodule
`default_nettype wire

[hw/rtl/rgb_box_blur_filter_unit.sv]
// Top level of the RGB box blur filter.
//   channel  | handshake          | beat
//   input    | in_valid/in_stall  | flush, red_in, green_in, blue_in
//   output   | out_valid/out_stall| red/green/blue_out, out_column, out_row, end_of_frame
//   config   | cfg_write          | cfg_index, cfg_data
// One beat at a time. A beat with no result due passes the check and test states;
// a result runs the raster divide, and an interior pixel also the N-column window
// sweep and three channel divides on the iterative divider.
// Reset clears counters and state; the line store is not cleared.
// The next input beat is taken while a result waits on a stalled output.
`default_nettype none
module rgb_box_blur_filter_unit
    import bbf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             flush,
    input  wire logic [7:0]       red_in,
    input  wire logic [7:0]       green_in,
    input  wire logic [7:0]       blue_in,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic      [7:0]       red_out,
    output logic      [7:0]       green_out,
    output logic      [7:0]       blue_out,
    output logic      [COL_W-1:0] out_column,
    output logic      [ROW_W-1:0] out_row,
    output logic                  end_of_frame,
    input  wire logic             cfg_write,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [DIM_W-1:0] cfg_data
);
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_CHECK = 13'b0000000000010,
        S_TEST  = 13'b0000000000100,
        S_DIVXY = 13'b0000000001000,
        S_MOD   = 13'b0000000010000,
        S_SETUP = 13'b0000000100000,
        S_WIN   = 13'b0000001000000,
        S_MERGE = 13'b0000010000000,
        S_DIVC  = 13'b0000100000000,
        S_DIVCW = 13'b0001000000000,
        S_PASS  = 13'b0010000000000,
        S_PASS2 = 13'b0100000000000,
        S_EMIT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [WIN_W-1:0] win_reg;
    logic [DIM_W-1:0] fw_reg, fh_reg;

    logic [WIN_W-1:0] n_eff, h_eff, n_or;
    logic [DIM_W-1:0] w_eff, hgt_eff;

    logic [COL_W-1:0]  in_col_reg;
    logic [DIM_W-1:0]  in_row_reg;
    logic [BANK_W-1:0] in_bank_reg;
    logic [IDX_W-1:0]  emit_reg;

    logic [RCV_W-1:0]  rcv_reg, lag_reg, total_reg;
    logic              complete_reg;
    logic [IDX_W-1:0]  y_reg, q_reg;
    logic [COL_W-1:0]  x_reg;
    logic [BANK_W-1:0] ym_reg, base_reg;
    logic              inter_reg;
    logic [5:0]        area_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [1:0]        ch_reg;
    pix_t              blur_reg;

    logic              out_valid_reg;
    pix_t              out_pix_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic              out_eof_reg;

    logic              accept, store_ok, emit_due, out_free, last_pix;
    logic [PROD_W-1:0] mprod;
    logic [IDX_W-1:0]  ym_full;
    logic [BANK_W-1:0] ym_w, base_w;
    logic              inter_w;
    logic [COL_W-1:0]  rd_addr;
    logic              div_start, div_done;
    logic [IDX_W-1:0]  div_dvd, div_quot;
    logic [DIM_W-1:0]  div_dvs, div_rem;
    logic [SUM_W-1:0]  sum_r, sum_g, sum_b, sum_sel;
    pix_t              pass_pix, wr_pix, final_pix;
    lane_ctl_t         lane_ctl [MAX_WINDOW];
    lane_sum_t         lane_acc [MAX_WINDOW];
    pix_t              lane_pix [MAX_WINDOW];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= WIN_W'(3);
            fw_reg  <= DIM_W'(640);
            fh_reg  <= DIM_W'(480);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WINDOW: win_reg <= cfg_data[WIN_W-1:0];
                CFG_WIDTH:  fw_reg  <= cfg_data;
                CFG_HEIGHT: fh_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        n_or  = win_reg | WIN_W'(1);
        n_eff = (n_or > WIN_W'(WIN_CAP)) ? WIN_W'(WIN_CAP) : n_or;
        h_eff = n_eff >> 1;
        priority if (fw_reg == '0)                w_eff = DIM_W'(1);
        else if (fw_reg > DIM_W'(MAX_WIDTH))      w_eff = DIM_W'(MAX_WIDTH);
        else                                      w_eff = fw_reg;
        priority if (fh_reg == '0)                hgt_eff = DIM_W'(1);
        else if (fh_reg > DIM_W'(MAX_HEIGHT))     hgt_eff = DIM_W'(MAX_HEIGHT);
        else                                      hgt_eff = fh_reg;
    end

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign store_ok = accept && !flush && (in_row_reg < hgt_eff);
    assign out_free = !out_valid_reg || !out_stall;
    assign emit_due = complete_reg
        || ((RCV_W+1)'(emit_reg) + (RCV_W+1)'(lag_reg) < (RCV_W+1)'(rcv_reg));
    assign last_pix = ((RCV_W+1)'(emit_reg) + (RCV_W+1)'(1)) >= (RCV_W+1)'(total_reg);
    assign wr_pix   = '{r: red_in, g: green_in, b: blue_in};

    // bank of y mod MAX_WINDOW, window base bank and interior test
    assign mprod   = PROD_W'(y_reg) * PROD_W'(MOD_RECIP);
    assign ym_full = y_reg - IDX_W'(q_reg * IDX_W'(MAX_WINDOW));
    assign ym_w    = ym_full[BANK_W-1:0];
    assign base_w  = (ym_w >= BANK_W'(h_eff)) ? (ym_w - BANK_W'(h_eff))
                   : BANK_W'(ym_w + BANK_W'(MAX_WINDOW) - BANK_W'(h_eff));
    assign inter_w = (y_reg >= IDX_W'(h_eff))
                  && ((y_reg + IDX_W'(h_eff)) < IDX_W'(hgt_eff))
                  && (x_reg >= COL_W'(h_eff))
                  && ((DIM_W'(x_reg) + DIM_W'(h_eff)) < w_eff);

    assign rd_addr = (state_reg == S_WIN)
        ? COL_W'(x_reg - COL_W'(h_eff) + COL_W'(cnt_reg)) : x_reg;

    always_comb
    begin
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            logic [BANK_W-1:0] off;
            off = (BANK_W'(k) >= base_reg) ? BANK_W'(BANK_W'(k) - base_reg)
                : BANK_W'(BANK_W'(k) + BANK_W'(MAX_WINDOW) - base_reg);
            lane_ctl[k].wr_en   = store_ok && (in_bank_reg == BANK_W'(k));
            lane_ctl[k].acc_clr = (state_reg == S_SETUP);
            lane_ctl[k].acc_en  = (state_reg == S_WIN) && (cnt_reg != '0)
                               && (CNT_W'(off) < CNT_W'(n_eff));
        end
    end

    genvar gk;
    generate
        for (gk = 0; gk < MAX_WINDOW; gk++)
        begin : g_lane
            bbf_lane u_lane (
                .clk     (clk),
                .ctl     (lane_ctl[gk]),
                .wr_addr (in_col_reg),
                .wr_pix  (wr_pix),
                .rd_addr (rd_addr),
                .rd_pix  (lane_pix[gk]),
                .acc     (lane_acc[gk])
            );
        end
    endgenerate

    bbf_merge u_merge (
        .clk      (clk),
        .lane_acc (lane_acc),
        .lane_pix (lane_pix),
        .sel      (ym_reg),
        .cap_sum  (state_reg == S_MERGE),
        .cap_pix  (state_reg == S_PASS2),
        .sum_r    (sum_r),
        .sum_g    (sum_g),
        .sum_b    (sum_b),
        .pass_pix (pass_pix)
    );

    always_comb
    begin
        unique case (ch_reg)
            2'd0:    sum_sel = sum_r;
            2'd1:    sum_sel = sum_g;
            default: sum_sel = sum_b;
        endcase
    end

    assign div_start = ((state_reg == S_TEST) && emit_due) || (state_reg == S_DIVC);
    assign div_dvd   = (state_reg == S_TEST) ? emit_reg
                     : IDX_W'(IDX_W'(sum_sel) + IDX_W'(area_reg >> 1));
    assign div_dvs   = (state_reg == S_TEST) ? w_eff : DIM_W'(area_reg);

    bbf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quot     (div_quot),
        .rem      (div_rem),
        .done     (div_done)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_CHECK;
            S_CHECK: state_next = S_TEST;
            S_TEST:  state_next = emit_due ? S_DIVXY : S_IDLE;
            S_DIVXY: if (div_done) state_next = S_MOD;
            S_MOD:   state_next = S_SETUP;
            S_SETUP: state_next = inter_w ? S_WIN : S_PASS;
            S_WIN:   if (cnt_reg == CNT_W'(n_eff)) state_next = S_MERGE;
            S_MERGE: state_next = S_DIVC;
            S_DIVC:  state_next = S_DIVCW;
            S_DIVCW: if (div_done) state_next = (ch_reg == 2'd2) ? S_EMIT : S_DIVC;
            S_PASS:  state_next = S_PASS2;
            S_PASS2: state_next = S_EMIT;
            S_EMIT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign final_pix = inter_reg ? blur_reg : pass_pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_bank_reg   <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            ch_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (store_ok)
            begin
                if ((DIM_W'(in_col_reg) + DIM_W'(1)) >= w_eff)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + 1'b1;
                    in_bank_reg <= (in_bank_reg == BANK_W'(MAX_WINDOW - 1))
                                 ? '0 : in_bank_reg + 1'b1;
                end
                else
                begin
                    in_col_reg <= in_col_reg + 1'b1;
                end
            end
            if (state_reg == S_SETUP)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == S_WIN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (state_reg == S_MERGE)
            begin
                ch_reg <= '0;
            end
            else if ((state_reg == S_DIVCW) && div_done)
            begin
                ch_reg <= ch_reg + 1'b1;
            end
            if ((state_reg == S_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (last_pix)
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    in_bank_reg <= '0;
                    emit_reg    <= '0;
                end
                else
                begin
                    emit_reg <= emit_reg + 1'b1;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CHECK)
        begin
            rcv_reg      <= RCV_W'(in_row_reg * w_eff) + RCV_W'(in_col_reg);
            lag_reg      <= RCV_W'(DIM_W'(h_eff) * w_eff) + RCV_W'(h_eff);
            total_reg    <= RCV_W'(w_eff * hgt_eff);
            complete_reg <= (in_row_reg >= hgt_eff);
        end
        if ((state_reg == S_DIVXY) && div_done)
        begin
            y_reg <= div_quot;
            x_reg <= div_rem[COL_W-1:0];
        end
        if (state_reg == S_MOD)
        begin
            q_reg <= mprod[PROD_W-1:MOD_SHIFT];
        end
        if (state_reg == S_SETUP)
        begin
            ym_reg    <= ym_w;
            base_reg  <= base_w;
            inter_reg <= inter_w;
            area_reg  <= 6'(n_eff * n_eff);
        end
        if ((state_reg == S_DIVCW) && div_done)
        begin
            unique case (ch_reg)
                2'd0:    blur_reg.r <= div_quot[7:0];
                2'd1:    blur_reg.g <= div_quot[7:0];
                default: blur_reg.b <= div_quot[7:0];
            endcase
        end
        if ((state_reg == S_EMIT) && out_free)
        begin
            out_pix_reg <= final_pix;
            out_col_reg <= x_reg;
            out_row_reg <= y_reg[ROW_W-1:0];
            out_eof_reg <= last_pix;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red_out      = out_pix_reg.r;
    assign green_out    = out_pix_reg.g;
    assign blue_out     = out_pix_reg.b;
    assign out_column   = out_col_reg;
    assign out_row      = out_row_reg;
    assign end_of_frame = out_eof_reg;
endmodule
`default_nettype wire

[hw/rtl/bbf_checker.sv]
// Port-level checker for the box blur filter, bound to the top level.
`default_nettype none
module bbf_checker
    import bbf_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_stall,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic [7:0]       red_out,
    input wire logic [COL_W-1:0] out_column,
    input wire logic [ROW_W-1:0] out_row
);
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken on consecutive cycles");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(red_out) && $stable(out_column)
            && $stable(out_row))
        else $error("stalled beat changed");
endmodule

bind rgb_box_blur_filter_unit bbf_checker u_bbf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red_out    (red_out),
    .out_column (out_column),
    .out_row    (out_row)
);
`default_nettype wire
